// ===== sv/lfr_pkg.sv =====
// Package for the LIN frame receiver: word types, codes and the small helper functions.
// It has no dependencies. All other files in sv/ use it.
`timescale 1ns / 1ps

package lfr_pkg;

  // Default number of response data bytes.
  localparam int unsigned DATA_BYTES_DEF = 8;
  // Widths that the word fields fix.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ID_W      = 6;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned MAX_BYTES = PAYLOAD_W / BYTE_W;

  // Input action codes.
  localparam logic ACT_BREAK = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  // Result frame kinds.
  localparam logic KIND_HEADER   = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // This mask keeps the identifier bits of a protected ID byte.
  localparam logic [BYTE_W-1:0] PID_ID_MASK = 8'hFC;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic                 frame_kind;
    logic [ID_W-1:0]      frame_id;
    logic                 id_ok;
    logic [PAYLOAD_W-1:0] payload;
    logic [BYTE_W-1:0]    check_byte;
    logic                 check_ok;
  } out_word_t;

  // Builds the protected ID byte: ID in the upper six bits, P1 and P0 below.
  function automatic logic [BYTE_W-1:0] protect_id(input logic [ID_W-1:0] id);
    logic p1;
    logic p0;
    p1 = id[5] ^ id[4] ^ id[3] ^ id[1];
    p0 = id[4] ^ id[2] ^ id[1] ^ id[0];
    return {id, p1, p0};
  endfunction

  // Adds one byte with the carry out fed back into bit 0.
  function automatic logic [BYTE_W-1:0] carry_add(input logic [BYTE_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, acc} + {1'b0, b};
    return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
  endfunction

endpackage

// ===== sv/lfr_frame_core.sv =====
// Frame tracking for the LIN frame receiver: break flag, byte count, checksum and data store.
// It builds a result word in the same cycle as the accepted input word. Depends on lfr_pkg.
`timescale 1ns / 1ps

module lfr_frame_core #(
  parameter int unsigned DATA_BYTES = lfr_pkg::DATA_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lfr_pkg::in_word_t  in_word,
  output logic               res_valid,
  output lfr_pkg::out_word_t res_word
);

  localparam logic [lfr_pkg::CNT_W-1:0] HDR_CNT = lfr_pkg::CNT_W'(3);
  localparam logic [lfr_pkg::CNT_W-1:0] DATA_CNT = lfr_pkg::CNT_W'(DATA_BYTES);
  localparam logic [lfr_pkg::CNT_W-1:0] RSP_CNT = lfr_pkg::CNT_W'(DATA_BYTES + 1);

  logic                        brk_r;
  logic                        brk_nxt;
  logic [lfr_pkg::CNT_W-1:0]   count_r;
  logic [lfr_pkg::CNT_W-1:0]   count_nxt;
  logic [lfr_pkg::BYTE_W-1:0]  sum_r;
  logic [lfr_pkg::BYTE_W-1:0]  sum_nxt;
  logic [lfr_pkg::BYTE_W-1:0]  store_r [DATA_BYTES];

  logic                        is_byte;
  logic                        wr_en;
  logic [lfr_pkg::CNT_W-1:0]   count_inc;
  logic                        hdr_done;
  logic                        rsp_done;
  logic [lfr_pkg::ID_W-1:0]    rx_id;
  logic                        pid_ok;
  logic [lfr_pkg::PAYLOAD_W-1:0] payload;

  // Decode the word against the current count and flag.
  always_comb begin
    is_byte   = (in_word.action == lfr_pkg::ACT_BYTE);
    wr_en     = accept && is_byte && (count_r < DATA_CNT);
    count_inc = count_r + lfr_pkg::CNT_W'(1);
    hdr_done  = is_byte && brk_r && (count_inc == HDR_CNT);
    rsp_done  = is_byte && !hdr_done && (count_inc == RSP_CNT);
    rx_id     = lfr_pkg::ID_W'((in_word.rx_byte & lfr_pkg::PID_ID_MASK) >> 2);
    pid_ok    = (lfr_pkg::protect_id(rx_id) == in_word.rx_byte);
  end

  // Next state of the flag, count and running sum.
  always_comb begin
    brk_nxt   = brk_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (accept) begin
      if (!is_byte) begin
        brk_nxt = 1'b1;
      end else if (hdr_done) begin
        brk_nxt   = 1'b0;
        count_nxt = '0;
        sum_nxt   = '0;
      end else if (rsp_done) begin
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = count_inc;
        if (wr_en) begin
          sum_nxt = lfr_pkg::carry_add(sum_r, in_word.rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r   <= 1'b0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      brk_r   <= brk_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Data store: each entry is loaded when the count points at it.
  for (genvar k = 0; k < lfr_pkg::MAX_BYTES; k++) begin : g_store
    if (k < DATA_BYTES) begin : g_used
      always_ff @(posedge clk) begin
        if (wr_en && (count_r == lfr_pkg::CNT_W'(k))) begin
          store_r[k] <= in_word.rx_byte;
        end
      end
      assign payload[k*lfr_pkg::BYTE_W +: lfr_pkg::BYTE_W] = store_r[k];
    end else begin : g_unused
      assign payload[k*lfr_pkg::BYTE_W +: lfr_pkg::BYTE_W] = '0;
    end
  end

  // Result word; fields that do not belong to the frame kind are zero.
  always_comb begin
    res_valid = accept && (hdr_done || rsp_done);
    res_word  = '0;
    if (hdr_done) begin
      res_word.frame_kind = lfr_pkg::KIND_HEADER;
      res_word.frame_id   = pid_ok ? rx_id : '0;
      res_word.id_ok      = pid_ok;
    end else begin
      res_word.frame_kind = lfr_pkg::KIND_RESPONSE;
      res_word.payload    = payload;
      res_word.check_byte = in_word.rx_byte;
      res_word.check_ok   = (~sum_r == in_word.rx_byte);
    end
  end

endmodule

// ===== sv/lfr_out_stage.sv =====
// Output register with a skid stage for the LIN frame receiver result channel.
// It lets the core take a new word while a result waits. Depends on lfr_pkg.
`timescale 1ns / 1ps

module lfr_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  lfr_pkg::out_word_t res_word,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output lfr_pkg::out_word_t out_word
);

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               skid_valid_r;
  logic               skid_valid_nxt;
  lfr_pkg::out_word_t out_word_r;
  lfr_pkg::out_word_t skid_word_r;
  logic               load_out;

  // The output register may load when it is empty or its word is taken.
  always_comb begin
    load_out       = !out_valid_r || !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (load_out) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r <= skid_valid_r ? skid_word_r : res_word;
    end else if (res_valid) begin
      skid_word_r <= res_word;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/lin_frame_receiver.sv =====
// Top level of the LIN frame receiver (slave side, classic checksum).
// Instantiates lfr_frame_core and lfr_out_stage; depends on lfr_pkg.
//
//   channel  direction  handshake           word type
//   in_      input      in_valid, in_stall   lfr_pkg::in_word_t
//   out_     output     out_valid, out_stall lfr_pkg::out_word_t
//
// One input word is taken per cycle while in_stall is low; a header or response
// result reaches out_ via the output register, after the skid stage when stalled.
// Reset (rst_n low, synchronous) clears the break flag, byte count, sum and both
// output stages; the data store is not cleared.
// in_stall rises only when a result waits in the skid stage behind a stalled output.
`timescale 1ns / 1ps

module lin_frame_receiver #(
  parameter int unsigned DATA_BYTES = lfr_pkg::DATA_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lfr_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output lfr_pkg::out_word_t out_word
);

  logic               accept;
  logic               res_valid;
  logic               stage_full;
  lfr_pkg::out_word_t res_word;

  // A word is taken whenever the skid stage is free.
  assign in_stall = stage_full;
  assign accept   = in_valid && !stage_full;

  lfr_frame_core #(
    .DATA_BYTES (DATA_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  lfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_word  (res_word),
    .full      (stage_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for lin_frame_receiver: directed frames, then random LIN traffic.
// Results are predicted in the bench and compared word by word; depends on lfr_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DATA_BYTES = lfr_pkg::DATA_BYTES_DEF;
  localparam int ITEM_TARGET    = 1000;
  localparam int IDLE_PCT       = 23;
  localparam int STEADY_FROM    = 500;
  localparam int STEADY_TO      = 700;
  localparam int PRESSURE_AT    = 200;
  localparam int PRESSURE_LEN   = 80;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 1000;

  // One planned input word; a fixed row carries its expected frame typed in.
  typedef struct packed {
    lfr_pkg::in_word_t  word;
    logic               fixed;
    logic               gives;
    lfr_pkg::out_word_t want;
  } row_t;

  localparam lfr_pkg::out_word_t NO_FRAME  = '0;
  localparam lfr_pkg::out_word_t HDR_3F    = '{lfr_pkg::KIND_HEADER, 6'h3F, 1'b1, 64'h0,
                                               8'h00, 1'b0};
  localparam lfr_pkg::out_word_t HDR_BAD   = '{lfr_pkg::KIND_HEADER, 6'h00, 1'b0, 64'h0,
                                               8'h00, 1'b0};
  localparam lfr_pkg::out_word_t HDR_01    = '{lfr_pkg::KIND_HEADER, 6'h01, 1'b1, 64'h0,
                                               8'h00, 1'b0};
  localparam lfr_pkg::out_word_t RESP_ONES = '{lfr_pkg::KIND_RESPONSE, 6'h00, 1'b0,
                                               64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1};

  // Directed frames. Rows with fixed clear are checked against the predictor.
  localparam row_t SCRIPT [22] = '{
    '{'{lfr_pkg::ACT_BREAK, 8'hFF}, 1'b1, 1'b0, NO_FRAME},   // break straight after reset
    '{'{lfr_pkg::ACT_BREAK, 8'h00}, 1'b1, 1'b0, NO_FRAME},   // repeated break
    '{'{lfr_pkg::ACT_BYTE,  8'h55}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hAA}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFC}, 1'b1, 1'b1, HDR_3F},     // highest ID, parity good
    '{'{lfr_pkg::ACT_BYTE,  8'h12}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BREAK, 8'h7E}, 1'b0, 1'b0, NO_FRAME},   // break in the middle of a count
    '{'{lfr_pkg::ACT_BYTE,  8'h34}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'h01}, 1'b1, 1'b1, HDR_BAD},    // parity error
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BREAK, 8'h80}, 1'b0, 1'b0, NO_FRAME},   // break past the header point
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'h00}, 1'b1, 1'b1, RESP_ONES},  // all-ones data, checksum zero
    '{'{lfr_pkg::ACT_BYTE,  8'h00}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'hFF}, 1'b0, 1'b0, NO_FRAME},
    '{'{lfr_pkg::ACT_BYTE,  8'h05}, 1'b1, 1'b1, HDR_01}      // flag kept from the response
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  lfr_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  lfr_pkg::out_word_t out_word;

  row_t               plan [$];
  lfr_pkg::out_word_t frames_due [$];
  int                 taken = 0;
  int                 errors = 0;

  // Predictor state: break flag, byte count, running checksum and data bytes.
  logic       brk_flag = 1'b0;
  logic [3:0] byte_cnt = '0;
  logic [7:0] run_sum = '0;
  logic [7:0] rx_store [8] = '{default: 8'h00};

  lin_frame_receiver #(.DATA_BYTES(DATA_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Protected ID: identifier in the top six bits, two parity bits below.
  function automatic logic [7:0] pid_of(input logic [5:0] id);
    return {id, ^(id & 6'b111010), ^(id & 6'b010111)};
  endfunction

  // Eight-bit sum with the carry wrapped back into bit 0.
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'b0, s[8]};
  endfunction

  // Advances the predicted receiver by one word; returns 1 when a frame completes.
  function automatic bit decode_word(input lfr_pkg::in_word_t w,
                                     output lfr_pkg::out_word_t frame);
    logic [5:0] id;
    logic       ok;
    frame = '0;
    if (w.action == lfr_pkg::ACT_BREAK) begin
      brk_flag = 1'b1;
      return 1'b0;
    end
    if (byte_cnt < DATA_BYTES) begin
      rx_store[byte_cnt[2:0]] = w.rx_byte;
      run_sum = eac_add(run_sum, w.rx_byte);
    end
    byte_cnt = byte_cnt + 4'd1;
    if (brk_flag && byte_cnt == 4'd3) begin
      id = w.rx_byte[7:2];
      ok = (pid_of(id) == w.rx_byte);
      frame.frame_kind = lfr_pkg::KIND_HEADER;
      frame.frame_id = ok ? id : '0;
      frame.id_ok = ok;
      brk_flag = 1'b0;
      byte_cnt = '0;
      run_sum = '0;
      return 1'b1;
    end
    if (byte_cnt == DATA_BYTES + 1) begin
      for (int k = 0; k < DATA_BYTES; k++) frame.payload[8*k +: 8] = rx_store[k];
      frame.frame_kind = lfr_pkg::KIND_RESPONSE;
      frame.check_byte = w.rx_byte;
      frame.check_ok = (~run_sum == w.rx_byte);
      byte_cnt = '0;
      run_sum = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_item(input logic act, input logic [7:0] b);
    row_t r;
    r = '0;
    r.word.action = act;
    r.word.rx_byte = b;
    plan.push_back(r);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: builds the plan, then offers it word by word with random gaps.
  initial begin : sender
    int         sent;
    int         pick;
    logic [7:0] csum;
    logic [7:0] data;
    logic [5:0] fid;
    bit         steady;
    in_valid <= 1'b0;
    in_word <= '0;
    foreach (SCRIPT[i]) plan.push_back(SCRIPT[i]);
    // Mostly well-formed frames with random content, with some stray words between.
    while (plan.size() < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        add_item(lfr_pkg::ACT_BREAK, 8'($urandom));
        if ($urandom_range(9) == 0) add_item(lfr_pkg::ACT_BREAK, 8'($urandom));
        add_item(lfr_pkg::ACT_BYTE, ($urandom_range(1) == 0) ? 8'h55 : 8'($urandom));
        add_item(lfr_pkg::ACT_BYTE, 8'($urandom));
        fid = 6'($urandom);
        add_item(lfr_pkg::ACT_BYTE, ($urandom_range(3) != 0) ? pid_of(fid) : 8'($urandom));
        if ($urandom_range(9) < 7) begin
          csum = '0;
          for (int k = 0; k < DATA_BYTES; k++) begin
            if ($urandom_range(9) == 0) data = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
            else data = 8'($urandom);
            csum = eac_add(csum, data);
            add_item(lfr_pkg::ACT_BYTE, data);
          end
          add_item(lfr_pkg::ACT_BYTE, ($urandom_range(3) != 0) ? ~csum : 8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 3)) add_item(1'($urandom_range(1)), 8'($urandom));
      end
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    sent = 0;
    while (1) begin
      if (in_valid && !in_stall) sent++;
      // A stalled word is held as it is; otherwise offer the next one or rest.
      if (!(in_valid && in_stall)) begin
        steady = (sent >= STEADY_FROM && sent < STEADY_TO) ||
                 (sent >= PRESSURE_AT && sent < PRESSURE_AT + 40);
        if (sent < plan.size() && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_word <= plan[sent].word;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (sent == plan.size()) break;
      @(posedge clk);
    end

    // Drain the outstanding frames, then allow a short tail for strays.
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back the block up, and a quiet stretch.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && taken >= PRESSURE_AT) begin
        held = 1'b1;
        hold_left = PRESSURE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (taken >= STEADY_FROM && taken < STEADY_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Checks each delivered frame against the oldest expectation and predicts
  // the frame, if any, that each accepted word completes.
  always @(posedge clk) begin
    lfr_pkg::out_word_t due;
    lfr_pkg::out_word_t made;
    bit                 fires;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        report_error($sformatf("frame of kind %0d with none due", out_word.frame_kind));
      end else begin
        due = frames_due.pop_front();
        if (out_word.frame_kind !== due.frame_kind)
          report_error($sformatf("frame_kind %0d, wanted %0d",
                                 out_word.frame_kind, due.frame_kind));
        if (out_word.frame_id !== due.frame_id)
          report_error($sformatf("frame_id %h, wanted %h", out_word.frame_id, due.frame_id));
        if (out_word.id_ok !== due.id_ok)
          report_error($sformatf("id_ok %0d, wanted %0d", out_word.id_ok, due.id_ok));
        if (out_word.payload !== due.payload)
          report_error($sformatf("payload %h, wanted %h", out_word.payload, due.payload));
        if (out_word.check_byte !== due.check_byte)
          report_error($sformatf("check_byte %h, wanted %h",
                                 out_word.check_byte, due.check_byte));
        if (out_word.check_ok !== due.check_ok)
          report_error($sformatf("check_ok %0d, wanted %0d", out_word.check_ok, due.check_ok));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      fires = decode_word(in_word, made);
      if (plan[taken].fixed) begin
        if (plan[taken].gives) frames_due.push_back(plan[taken].want);
      end else if (fires) begin
        frames_due.push_back(made);
      end
      taken <= taken + 1;
    end
  end

  // Watchdog: ends the run when neither channel has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
